// ===== hw/rtl/k_smallest_tracker_top_macros.svh =====
// assertion macros for the k-smallest tracker
// no dependencies; included by the top level only
`ifndef K_SMALLEST_TRACKER_TOP_MACROS_SVH
`define K_SMALLEST_TRACKER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define KST_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("k-smallest tracker: same-cycle check failed");

// next-cycle implication, disabled in reset
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("k-smallest tracker: next-cycle check failed");

`endif

// ===== hw/rtl/kst_pkg.sv =====
// shared widths, reset values and data type for the k-smallest tracker
// no dependencies; used by kst_slot_mem and k_smallest_tracker_top
package kst_pkg;

    localparam int DATA_W       = 32;
    localparam int KEEP_W       = 5;
    localparam int SLOT_IDX_W   = 4;
    localparam int DEF_MAX_KEEP = 16;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

    typedef logic signed [DATA_W-1:0] data_t;

endpackage

// ===== hw/rtl/kst_slot_mem.sv =====
// slot storage: one write port, one read port, registered read data
// depends on kst_pkg for the data type
module kst_slot_mem #(
    parameter int MAX_KEEP = kst_pkg::DEF_MAX_KEEP,
    parameter int AW       = kst_pkg::SLOT_IDX_W
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  kst_pkg::data_t    wdata,
    input  logic [AW-1:0]     raddr,
    output kst_pkg::data_t    rdata
);
    import kst_pkg::*;

    data_t slot_mem [MAX_KEEP];
    data_t rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_mem[waddr] <= wdata;
        end
        rdata_reg <= slot_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/k_smallest_tracker_top.sv =====
// k-smallest tracker: keeps the k smallest signed values of a set in a slot memory.
// a value that only fills a slot is stored straight away; once k slots are full a value
// takes one pass over the slot memory read port to find the first maximum.
// the end mark adds k results on consecutive cycles (one too_few result if under k came).
// results cannot be stalled. async reset empties the set and sets keep_count to 16.
// depends on kst_pkg, kst_slot_mem and k_smallest_tracker_top_macros.svh
`include "k_smallest_tracker_top_macros.svh"

module k_smallest_tracker_top #(
    parameter int MAX_KEEP = kst_pkg::DEF_MAX_KEEP
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  kst_pkg::data_t                    sample_value,
    input  logic                              end_of_set,
    input  logic                              cfg_write,
    input  logic [kst_pkg::KEEP_W-1:0]        cfg_data,
    output logic                              strobe,
    output kst_pkg::data_t                    kept_value,
    output logic [kst_pkg::SLOT_IDX_W-1:0]    slot_index,
    output logic                              last_of_run,
    output logic                              too_few
);
    import kst_pkg::*;

    localparam int KW = $clog2(MAX_KEEP + 1);
    localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_REPORT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [KEEP_W-1:0]     keep_count_reg;
    logic [KW-1:0]         fill_reg, fill_next;
    logic [KW-1:0]         k_reg, k_next;
    data_t                 val_reg, val_next;
    logic                  last_reg, last_next;
    logic [AW-1:0]         idx_reg, idx_next;
    data_t                 max_reg, max_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic                  strobe_reg, strobe_next;
    logic [SLOT_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_few_reg, out_few_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    data_t                 mem_wdata;
    logic [AW-1:0]         mem_raddr;
    data_t                 mem_rdata;

    logic [7:0]            keep_ext;
    logic [7:0]            k_sel;
    logic [KW-1:0]         k_eff;
    logic [KW-1:0]         fill_inc;
    logic [KW-1:0]         idx_ext;
    logic [KW-1:0]         idx_inc;
    logic                  idx_at_end;
    data_t                 cand_max;
    logic [AW-1:0]         cand_pos;
    logic                  accept;

    // effective k: zero acts as one, large values clamp to the slot count
    always_comb
    begin
        keep_ext = 8'(keep_count_reg);
        if (keep_ext == 8'd0)
        begin
            k_sel = 8'd1;
        end
        else if (keep_ext > 8'(MAX_KEEP))
        begin
            k_sel = 8'(MAX_KEEP);
        end
        else
        begin
            k_sel = keep_ext;
        end
        k_eff = KW'(k_sel);
    end

    assign accept     = start && (state_reg == ST_IDLE);
    assign fill_inc   = fill_reg + KW'(1);
    assign idx_ext    = KW'(idx_reg);
    assign idx_inc    = idx_ext + KW'(1);
    assign idx_at_end = (idx_ext == (k_reg - KW'(1)));

    // running first maximum over the slot being read out this cycle
    always_comb
    begin
        if (idx_reg == '0)
        begin
            cand_max = mem_rdata;
            cand_pos = '0;
        end
        else if (mem_rdata > max_reg)
        begin
            cand_max = mem_rdata;
            cand_pos = idx_reg;
        end
        else
        begin
            cand_max = max_reg;
            cand_pos = pos_reg;
        end
    end

    // control sequencer
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        k_next        = k_reg;
        val_next      = val_reg;
        last_next     = last_reg;
        idx_next      = idx_reg;
        max_next      = max_reg;
        pos_next      = pos_reg;
        strobe_next   = 1'b0;
        out_idx_next  = out_idx_reg;
        out_last_next = out_last_reg;
        out_few_next  = out_few_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = sample_value;
        mem_raddr     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    k_next    = k_eff;
                    val_next  = sample_value;
                    last_next = end_of_set;
                    idx_next  = '0;
                    if (fill_reg < k_eff)
                    begin
                        // still filling: store in arrival order
                        mem_we    = 1'b1;
                        mem_waddr = AW'(fill_reg);
                        fill_next = fill_inc;
                        if (end_of_set)
                        begin
                            fill_next = '0;
                            if (fill_inc < k_eff)
                            begin
                                strobe_next   = 1'b1;
                                out_idx_next  = '0;
                                out_last_next = 1'b1;
                                out_few_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_REPORT;
                            end
                        end
                    end
                    else
                    begin
                        // slot 0 read is already in flight from idle
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                max_next = cand_max;
                pos_next = cand_pos;
                if (idx_at_end)
                begin
                    // replace the first maximum when strictly smaller
                    if (val_reg < cand_max)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cand_pos;
                        mem_wdata = val_reg;
                    end
                    idx_next = '0;
                    if (last_reg)
                    begin
                        state_next = ST_REPORT;
                        fill_next  = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next  = AW'(idx_inc);
                    mem_raddr = AW'(idx_inc);
                end
            end
            ST_REPORT:
            begin
                // one slot read per cycle, result shown when the data returns
                mem_raddr     = idx_reg;
                strobe_next   = 1'b1;
                out_idx_next  = SLOT_IDX_W'(idx_reg);
                out_last_next = idx_at_end;
                out_few_next  = 1'b0;
                if (idx_at_end)
                begin
                    state_next = ST_IDLE;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = AW'(idx_inc);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            keep_count_reg <= KEEP_RESET;
            fill_reg       <= '0;
            idx_reg        <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
            if (cfg_write)
            begin
                keep_count_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        val_reg      <= val_next;
        last_reg     <= last_next;
        max_reg      <= max_next;
        pos_reg      <= pos_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
        out_few_reg  <= out_few_next;
    end

    kst_slot_mem #(
        .MAX_KEEP (MAX_KEEP),
        .AW       (AW)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // outputs
    assign busy        = (state_reg != ST_IDLE);
    assign strobe      = strobe_reg;
    assign kept_value  = out_few_reg ? data_t'(0) : mem_rdata;
    assign slot_index  = out_idx_reg;
    assign last_of_run = out_last_reg;
    assign too_few     = out_few_reg;

    // checks
    `KST_ASSERT_IMPLY(a_few_is_last, clk, rst_n, strobe_reg && out_few_reg, out_last_reg)
    `KST_ASSERT_IMPLY(a_scan_full, clk, rst_n, state_reg == ST_SCAN, fill_reg >= k_reg)
    `KST_ASSERT_IMPLY(a_report_empty, clk, rst_n, state_reg == ST_REPORT, fill_reg == '0)
    `KST_ASSERT_NEXT(a_write_ends_scan, clk, rst_n, mem_we, state_reg != ST_SCAN)

endmodule
